FILE: hw/rtl/hsl2rgb_pkg.sv
// Package for the HSL to RGB converter: item structs and fixed-point constants.
// No dependencies; imported by hsl2rgb_chan, hsl_to_rgb_converter, hsl_to_rgb_checker and tb.
package hsl2rgb_pkg;

    // One input item: hue in degrees, saturation and lightness in percent
    typedef struct packed {
        logic [15:0] hue_degrees;
        logic [7:0]  saturation_pct;
        logic [7:0]  lightness_pct;
    } hsl_in_t;

    // One result item: truncated channel intensities
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_out_t;

    // Hue range and the one-third and two-thirds offsets
    localparam int unsigned HUE_FULL  = 360;
    localparam int unsigned HUE_THIRD = HUE_FULL / 3;
    localparam int unsigned HUE_TWO_THIRDS = 2 * HUE_FULL / 3;

    // Hue breakpoints of the ramp, in degrees
    localparam int unsigned SIXTH     = 60;
    localparam int unsigned HALF_HUE  = 3 * SIXTH;
    localparam int unsigned FOUR_SIXTH = 4 * SIXTH;

    // Percent full scale and the lightness split point
    localparam int unsigned PCT_MAX  = 100;
    localparam int unsigned PCT_HALF = PCT_MAX / 2;

    // Reciprocal for hue / 360: floor(2^23 / 360), estimate low by at most one
    localparam int unsigned HUE_RECIP = 23301;
    localparam int unsigned HUE_SHIFT = 23;

    // Channel = floor(num * 255 / 600000) = floor(num * 17 / 40000)
    localparam int unsigned CHAN_MUL   = 17;
    localparam int unsigned CHAN_DIV   = 40000;
    // floor(2^30 / 40000), estimate low by at most one
    localparam int unsigned CHAN_RECIP = 26843;
    localparam int unsigned CHAN_SHIFT = 30;

    // Clock edges from accepted item to result strobe
    localparam int unsigned LATENCY = 7;

endpackage

FILE: hw/rtl/hsl2rgb_chan.sv
// One color channel back end: ramp product, scale to 0..255, reciprocal divide.
// Depends on hsl2rgb_pkg. Four register stages, free running.
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
(
    input  logic        clk,
    input  logic [19:0] base,    // 60 * t2
    input  logic [13:0] span,    // t1 - t2
    input  logic [5:0]  slope,   // ramp position 0..60
    output logic [7:0]  level
);

    logic [19:0] prod_reg;
    logic [19:0] base_reg;
    logic [23:0] scaled_reg;
    logic [23:0] scaled_d_reg;
    logic [8:0]  quot_reg;
    logic [7:0]  level_reg;

    logic [19:0] prod_next;
    logic [19:0] num;
    logic [23:0] scaled_next;
    logic [38:0] recip_prod;
    logic [8:0]  quot_next;
    logic [24:0] quot_x_div;
    logic [24:0] remainder;
    logic [7:0]  level_next;

    // Stage 4: ramp slope times span
    assign prod_next = 20'(span) * 20'(slope);

    // Stage 5: numerator in units of 1/600000, scaled by 17
    assign num         = base_reg + prod_reg;
    assign scaled_next = 24'(num) * 24'(CHAN_MUL);

    // Stage 6: quotient estimate by reciprocal
    assign recip_prod = 39'(scaled_reg) * 39'(CHAN_RECIP);
    assign quot_next  = 9'(recip_prod >> CHAN_SHIFT);

    // Stage 7: correct the estimate by one compare
    assign quot_x_div = 25'(quot_reg) * 25'(CHAN_DIV);
    assign remainder  = {1'b0, scaled_d_reg} - quot_x_div;

    always_comb
    begin
        if (remainder >= 25'(CHAN_DIV))
        begin
            level_next = quot_reg[7:0] + 8'd1;
        end
        else
        begin
            level_next = quot_reg[7:0];
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        base_reg     <= base;
        scaled_reg   <= scaled_next;
        scaled_d_reg <= scaled_reg;
        quot_reg     <= quot_next;
        level_reg    <= level_next;
    end

    assign level = level_reg;

endmodule

FILE: hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter top level: front end stages and three channel back ends.
// Depends on hsl2rgb_pkg and hsl2rgb_chan.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+---------------------------------------
//   input    | hsl (hsl_in_t)        | taken when start is high, busy is low
//   result   | rgb (rgb_out_t)       | one cycle, marked by rgb_valid
//
// An item accepted at one edge shows its result, for one cycle, after all
// the stages listed below. A new item is taken every cycle; busy stays low
// since the pipeline never holds. The seven stages are: hue reduce estimate,
// hue wrap and t1/t2, channel hue and ramp slope, span product, scaled
// numerator, reciprocal quotient, quotient correction. Reset clears the valid
// bits only; the receiver cannot stall, so nothing waits in the pipeline.
module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  hsl_in_t  hsl,
    output logic     rgb_valid,
    output rgb_out_t rgb
);

    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    logic               accept;

    // Stage 1 registers
    logic [15:0] hue_reg;
    logic [7:0]  hue_quot_reg;
    logic [6:0]  sat_reg;
    logic [6:0]  light_reg;
    logic [13:0] ls_reg;

    // Stage 2 registers
    logic [8:0]  hue_mod_reg;
    logic [13:0] t1_reg;
    logic [13:0] t2_reg;

    // Stage 3 registers
    logic [19:0] base_reg;
    logic [13:0] span_reg;
    logic [5:0]  slope_reg [3];

    // Stage 1 logic
    logic [6:0]  sat_next;
    logic [6:0]  light_next;
    logic [30:0] hue_recip_prod;
    logic [7:0]  hue_quot_next;
    logic [13:0] ls_next;

    // Stage 2 logic
    logic [15:0] hue_quot_x;
    logic [15:0] hue_rem;
    logic [8:0]  hue_mod_next;
    logic [13:0] light100;
    logic [14:0] sat100;
    logic [13:0] t1_next;
    logic [14:0] t2_wide;

    // Stage 3 logic
    logic [9:0]  hue_plus1;
    logic [9:0]  hue_plus2;
    logic [8:0]  chan_hue [3];
    logic [5:0]  slope_next [3];
    logic [7:0]  level [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance valid bits with the data
    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: clamp percents, estimate hue / 360, form L*S
    assign sat_next   = (hsl.saturation_pct > 8'(PCT_MAX)) ? 7'(PCT_MAX)
                                                           : hsl.saturation_pct[6:0];
    assign light_next = (hsl.lightness_pct > 8'(PCT_MAX)) ? 7'(PCT_MAX)
                                                          : hsl.lightness_pct[6:0];
    assign hue_recip_prod = 31'(hsl.hue_degrees) * 31'(HUE_RECIP);
    assign hue_quot_next  = 8'(hue_recip_prod >> HUE_SHIFT);
    assign ls_next        = 14'(sat_next) * 14'(light_next);

    always_ff @(posedge clk)
    begin
        hue_reg      <= hsl.hue_degrees;
        hue_quot_reg <= hue_quot_next;
        sat_reg      <= sat_next;
        light_reg    <= light_next;
        ls_reg       <= ls_next;
    end

    // Stage 2: finish hue mod 360, form t1 and t2
    assign hue_quot_x = 16'(hue_quot_reg) * 16'(HUE_FULL);
    assign hue_rem    = hue_reg - hue_quot_x;
    assign hue_mod_next = (hue_rem[9:0] >= 10'(HUE_FULL))
                          ? 9'(hue_rem[9:0] - 10'(HUE_FULL)) : hue_rem[8:0];

    assign light100 = 14'(light_reg) * 14'(PCT_MAX);
    assign sat100   = 15'(sat_reg) * 15'(PCT_MAX);

    always_comb
    begin
        if (light_reg < 7'(PCT_HALF))
        begin
            t1_next = light100 + ls_reg;
        end
        else
        begin
            t1_next = 14'(15'(light100) + sat100 - 15'(ls_reg));
        end
    end

    assign t2_wide = {light100, 1'b0} - 15'(t1_next);

    always_ff @(posedge clk)
    begin
        hue_mod_reg <= hue_mod_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_wide[13:0];
    end

    // Stage 3: channel hues (red +120, green +0, blue +240) and ramp slopes
    assign hue_plus1 = 10'(hue_mod_reg) + 10'(HUE_THIRD);
    assign hue_plus2 = 10'(hue_mod_reg) + 10'(HUE_TWO_THIRDS);
    assign chan_hue[0] = (hue_plus1 >= 10'(HUE_FULL)) ? 9'(hue_plus1 - 10'(HUE_FULL))
                                                      : hue_plus1[8:0];
    assign chan_hue[1] = hue_mod_reg;
    assign chan_hue[2] = (hue_plus2 >= 10'(HUE_FULL)) ? 9'(hue_plus2 - 10'(HUE_FULL))
                                                      : hue_plus2[8:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            priority if (chan_hue[i] < 9'(SIXTH))
            begin
                slope_next[i] = chan_hue[i][5:0];
            end
            else if (chan_hue[i] < 9'(HALF_HUE))
            begin
                slope_next[i] = 6'(SIXTH);
            end
            else if (chan_hue[i] < 9'(FOUR_SIXTH))
            begin
                slope_next[i] = 6'(9'(FOUR_SIXTH) - chan_hue[i]);
            end
            else
            begin
                slope_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= 20'(t2_reg) * 20'(SIXTH);
        span_reg  <= t1_reg - t2_reg;
        slope_reg <= slope_next;
    end

    // Stages 4 to 7: one back end per channel
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        hsl2rgb_chan u_chan (
            .clk   (clk),
            .base  (base_reg),
            .span  (span_reg),
            .slope (slope_reg[c]),
            .level (level[c])
        );
    end

    // Drive the result item
    assign rgb_valid = valid_reg[LATENCY-1];
    assign rgb.red   = level[0];
    assign rgb.green = level[1];
    assign rgb.blue  = level[2];

    // Every accepted item gives its strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY rgb_valid)
        else $error("result strobe missing after accepted item");

    // No strobe without an item accepted the fixed latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> $past(accept, LATENCY))
        else $error("result strobe without accepted item");

    // Zero saturation gives a gray result
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && $past(hsl.saturation_pct == 8'd0, LATENCY))
        |-> (rgb.red == rgb.green && rgb.green == rgb.blue))
        else $error("zero saturation item did not give gray");

endmodule

FILE: verif/hsl_to_rgb_checker.sv
// Checker for the HSL to RGB converter: predicts each pixel's RGB from the
// accepted HSL item and compares it with the strobed result, oldest first.
// Depends on hsl2rgb_pkg for the item structs.
module hsl_to_rgb_checker
    import hsl2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  hsl_in_t     hsl,
    input  logic        rgb_valid,
    input  rgb_out_t    rgb,
    output int unsigned mismatch_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEG_FULL   = 360;
    localparam int unsigned DEG_THIRD  = 120;
    localparam int unsigned DEG_SIXTH  = 60;
    localparam int unsigned PCT_TOP    = 100;
    localparam int unsigned PCT_MID    = 50;
    localparam int unsigned LEVEL_TOP  = 255;
    // Ramp numerator is in units of 1/600000
    localparam int unsigned RAMP_SCALE = 600000;

    rgb_out_t expected_rgb_q[$];

    // Sample the piecewise-linear ramp at channel hue deg and scale to 0..255
    function automatic logic [7:0] ramp_level(int unsigned deg, int unsigned t_hi,
                                              int unsigned t_lo);
        int unsigned slope;
        int unsigned num;
        slope = t_hi - t_lo;
        if (deg < DEG_SIXTH)
            num = DEG_SIXTH * t_lo + slope * deg;
        else if (deg < 3 * DEG_SIXTH)
            num = DEG_SIXTH * t_hi;
        else if (deg < 4 * DEG_SIXTH)
            num = DEG_SIXTH * t_lo + slope * (4 * DEG_SIXTH - deg);
        else
            num = DEG_SIXTH * t_lo;
        num = num * LEVEL_TOP / RAMP_SCALE;
        if (num > LEVEL_TOP)
            num = LEVEL_TOP;
        return num[7:0];
    endfunction

    // Convert one pixel exactly, in units of 1/10000 for t1 and t2
    function automatic rgb_out_t predict_rgb(hsl_in_t px);
        int unsigned hue;
        int unsigned sat;
        int unsigned lit;
        int unsigned t_hi;
        int unsigned t_lo;
        rgb_out_t    color;
        hue = px.hue_degrees % DEG_FULL;
        sat = (px.saturation_pct > PCT_TOP) ? PCT_TOP : px.saturation_pct;
        lit = (px.lightness_pct > PCT_TOP) ? PCT_TOP : px.lightness_pct;
        if (lit < PCT_MID)
            t_hi = lit * (PCT_TOP + sat);
        else
            t_hi = lit * PCT_TOP + sat * PCT_TOP - lit * sat;
        t_lo = 2 * lit * PCT_TOP - t_hi;
        color.red   = ramp_level((hue + DEG_THIRD) % DEG_FULL, t_hi, t_lo);
        color.green = ramp_level(hue, t_hi, t_lo);
        color.blue  = ramp_level((hue + DEG_FULL - DEG_THIRD) % DEG_FULL, t_hi, t_lo);
        return color;
    endfunction

    // Report one channel and return 1 when it differs
    function automatic bit channel_differs(string chan, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queue a prediction per accepted item, compare each result with the oldest one
    always @(posedge clk or negedge rst_n) begin
        rgb_out_t want;
        bit       bad;
        if (!rst_n) begin
            expected_rgb_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else begin
            bad = 1'b0;
            if (start && !busy)
                expected_rgb_q.push_back(predict_rgb(hsl));
            if (rgb_valid) begin
                if (expected_rgb_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, rgb.red, rgb.green, rgb.blue);
                    bad = 1'b1;
                end
                else begin
                    want = expected_rgb_q.pop_front();
                    bad |= channel_differs("red", want.red, rgb.red);
                    bad |= channel_differs("green", want.green, rgb.green);
                    bad |= channel_differs("blue", want.blue, rgb.blue);
                end
            end
            if (bad)
                mismatch_count <= mismatch_count + 1;
            pending_count <= expected_rgb_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for hsl_to_rgb_converter: clock, reset, pixel stimulus, verdict.
// Depends on hsl2rgb_pkg, hsl_to_rgb_converter and hsl_to_rgb_checker.
module tb;
    import hsl2rgb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_PIXELS = 800;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_LIMIT   = 1000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    hsl_in_t     hsl;
    logic        rgb_valid;
    rgb_out_t    rgb;
    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned cycle_count = 0;

    hsl_to_rgb_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .hsl       (hsl),
        .rgb_valid (rgb_valid),
        .rgb       (rgb)
    );

    hsl_to_rgb_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hsl            (hsl),
        .rgb_valid      (rgb_valid),
        .rgb            (rgb),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one pixel until taken, then drop start for the gap given
    task automatic send_pixel(hsl_in_t px, int unsigned gap);
        start <= 1'b1;
        hsl   <= px;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            hsl   <= hsl_in_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Draw a pixel: mostly in-range percents; a quarter of hues near the ramp corners
    function automatic hsl_in_t random_pixel();
        hsl_in_t px;
        case ($urandom_range(0, 3))
            0:       px.hue_degrees = 16'($urandom_range(0, 65535));
            1:       px.hue_degrees = 16'(60 * $urandom_range(0, 11)
                                          + $urandom_range(0, 2) - 1);
            default: px.hue_degrees = 16'($urandom_range(0, 719));
        endcase
        px.saturation_pct = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 100));
        px.lightness_pct  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 100));
        if ($urandom_range(0, 15) == 0)
            px.saturation_pct = 8'd0;
        return px;
    endfunction

    initial
    begin
        bit          back_to_back;
        int unsigned waited;
        rst_n = 1'b0;
        start = 1'b0;
        hsl   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk hue across every ramp corner at full saturation, mid lightness
        send_pixel(hsl_in_t'{16'd0,     8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd59,    8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd60,    8'd100, 8'd50}, 1);
        send_pixel(hsl_in_t'{16'd119,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd120,   8'd100, 8'd50}, 3);
        send_pixel(hsl_in_t'{16'd179,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd180,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd239,   8'd100, 8'd50}, 2);
        send_pixel(hsl_in_t'{16'd240,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd300,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd359,   8'd100, 8'd50}, 5);
        // Large hues wrap modulo 360
        send_pixel(hsl_in_t'{16'd360,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd719,   8'd100, 8'd50}, 0);
        send_pixel(hsl_in_t'{16'd65535, 8'd100, 8'd50}, 16);
        // Zero saturation gives gray
        send_pixel(hsl_in_t'{16'd200,   8'd0,   8'd0},   0);
        send_pixel(hsl_in_t'{16'd200,   8'd0,   8'd37},  0);
        send_pixel(hsl_in_t'{16'd200,   8'd0,   8'd100}, 0);
        send_pixel(hsl_in_t'{16'd0,     8'd0,   8'd255}, 4);
        // Clamp out-of-range percents, straddle the lightness split
        send_pixel(hsl_in_t'{16'd90,    8'd255, 8'd255}, 0);
        send_pixel(hsl_in_t'{16'd10,    8'd101, 8'd101}, 0);
        send_pixel(hsl_in_t'{16'd30,    8'd100, 8'd49},  0);
        send_pixel(hsl_in_t'{16'd30,    8'd100, 8'd51},  7);
        send_pixel(hsl_in_t'{16'd65000, 8'd63,  8'd255}, 0);

        // Random pixels in stretches of 40, each stretch back-to-back or with random gaps
        back_to_back = 1'b0;
        for (int unsigned n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n % 40 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            send_pixel(random_pixel(), back_to_back ? 0 : $urandom_range(0, 16));
        end
        start <= 1'b0;

        // Drain the pipeline, then give stray results time to show
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl2rgb_chan.sv
hw/rtl/hsl_to_rgb_converter.sv
verif/hsl_to_rgb_checker.sv
verif/tb.sv
